>>> design/spbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spbs_pkg: shared types and constants for the sleep package byte scanner
// Word format passed from the front classifier to the match engine, the
// byte codes the scanner looks for, and the default sizes.
// ----------------------------------------------------------------------------
package spbs_pkg;

   // sizes
   localparam int DEF_MAX_PENDING = 8;
   localparam int SEARCH_LIMIT    = 30;
   localparam int HISTORY_DEPTH   = 40;
   localparam int QUEUE_DEPTH     = 4;

   // match age: the name's first byte is three bytes old when it is seen
   localparam int AGE_W          = 7;
   localparam int NAME_START_AGE = 3;
   localparam int AGE_LIMIT      = 64;
   localparam int KILL_AGE       = (HISTORY_DEPTH + 4 < AGE_LIMIT) ?
                                   (HISTORY_DEPTH + 4) : AGE_LIMIT;

   // byte codes
   localparam logic [7:0] NAME_SEP    = 8'h5F;
   localparam logic [7:0] NAME_S      = 8'h53;
   localparam logic [7:0] NAME_5      = 8'h35;
   localparam logic [7:0] PKG_OP      = 8'h12;
   localparam logic [7:0] LEN_MASK    = 8'hC0;
   localparam logic [7:0] BYTE_PREFIX = 8'h0A;
   localparam logic [7:0] SMALL_MAX   = 8'h0F;
   localparam int         VALUE_SHIFT = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       name_hit;
      logic       is_pkg;
      logic       is_prefix;
      logic       is_small;
      logic [2:0] skip;
   } spbs_word_type;

endpackage
`default_nettype wire

>>> design/spbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spbs_front: byte classifier
// Takes table bytes, spots the four byte name, and tags each byte with the
// decodes the match engine needs before pushing it into the queue.
// ----------------------------------------------------------------------------
module spbs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last_byte,
   input  wire logic                  queue_full,
   output logic                       push_valid,
   output spbs_pkg::spbs_word_type    push_word
);

   logic [7:0] b1_ff, b2_ff, b3_ff;
   logic [1:0] pos_ff, pos_in;
   logic       accept;

   assign req_stall  = queue_full;
   assign push_valid = req_valid;
   assign accept     = req_valid && !queue_full;

   always_comb begin
      push_word.data      = req_data_byte;
      push_word.last      = req_last_byte;
      push_word.name_hit  = (pos_ff == 2'd3) && !req_last_byte &&
                            (b3_ff == spbs_pkg::NAME_SEP) && (b2_ff == spbs_pkg::NAME_S) &&
                            (b1_ff == spbs_pkg::NAME_5) &&
                            (req_data_byte == spbs_pkg::NAME_SEP);
      push_word.is_pkg    = (req_data_byte == spbs_pkg::PKG_OP);
      push_word.is_prefix = (req_data_byte == spbs_pkg::BYTE_PREFIX);
      push_word.is_small  = (req_data_byte <= spbs_pkg::SMALL_MAX);
      // lead byte: one length byte, or (lead >> 6) + 1 of them
      if ((req_data_byte & spbs_pkg::LEN_MASK) != 8'h00)
         push_word.skip = {1'b0, req_data_byte[7:6]} + 3'd1;
      else
         push_word.skip = 3'd1;
   end

   always_comb begin
      if (req_last_byte)
         pos_in = 2'd0;
      else if (pos_ff != 2'd3)
         pos_in = pos_ff + 2'd1;
      else
         pos_in = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b3_ff <= b2_ff;
         b2_ff <= b1_ff;
         b1_ff <= req_data_byte;
      end
   end

endmodule
`default_nettype wire

>>> design/spbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spbs_queue: short word queue
// Decouples the classifier from the match engine so each side stalls alone.
// ----------------------------------------------------------------------------
module spbs_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire spbs_pkg::spbs_word_type  push_word,
   output logic                          full,
   output logic                          pop_valid,
   output spbs_pkg::spbs_word_type       pop_word,
   input  wire logic                     pop
);

   localparam int Depth = spbs_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   spbs_pkg::spbs_word_type word_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = word_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CntW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         word_ff[wr_ptr_ff] <= push_word;
   end

endmodule
`default_nettype wire

>>> design/spbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spbs_back: match engine
// Keeps one tracker per open name match and steps all of them on each word.
// Gives the answer on the first success, or not-found on the table's end.
// ----------------------------------------------------------------------------
module spbs_back #(
   parameter int MAX_PENDING = spbs_pkg::DEF_MAX_PENDING
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     word_valid,
   input  wire spbs_pkg::spbs_word_type  word,
   output logic                          word_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_found,
   output logic [15:0]                   rsp_sleep_control_bits
);

   localparam int IdxW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
   localparam int AgeW = spbs_pkg::AGE_W;
   localparam logic [AgeW-1:0] KillAge    = AgeW'(spbs_pkg::KILL_AGE);
   localparam logic [AgeW-1:0] LastSearch = AgeW'(spbs_pkg::SEARCH_LIMIT - 1);
   localparam logic [AgeW-1:0] StartAge   = AgeW'(spbs_pkg::NAME_START_AGE);

   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_SKIP   = 3'd2;
   localparam logic [2:0] PH_ELEM   = 3'd3;
   localparam logic [2:0] PH_VALUE  = 3'd4;

   logic [MAX_PENDING-1:0] valid_ff, valid_in;
   logic [2:0]             phase_ff [MAX_PENDING];
   logic [2:0]             phase_in [MAX_PENDING];
   logic [AgeW-1:0]        age_ff   [MAX_PENDING];
   logic [AgeW-1:0]        age_in   [MAX_PENDING];
   logic [2:0]             skip_ff  [MAX_PENDING];
   logic [2:0]             skip_in  [MAX_PENDING];

   logic [2:0]             lane_phase_nx [MAX_PENDING];
   logic [AgeW-1:0]        lane_age_nx   [MAX_PENDING];
   logic [2:0]             lane_skip_nx  [MAX_PENDING];
   logic [MAX_PENDING-1:0] lane_keep, lane_hit;

   logic            answer_ff, answer_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff;
   logic [15:0]     rsp_bits_ff;
   logic            success, scan_live, emit, ins_ok;
   logic [IdxW-1:0] ins_idx;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_found              = rsp_found_ff;
   assign rsp_sleep_control_bits = rsp_bits_ff;

   assign word_pop  = word_valid && (!rsp_valid_ff || !rsp_stall);
   assign scan_live = word_pop && !answer_ff;
   assign success   = |lane_hit;
   assign emit      = scan_live && (success || word.last);

   // step every tracker on the current byte
   always_comb begin
      for (int i = 0; i < MAX_PENDING; i++) begin
         lane_age_nx[i]   = age_ff[i] + AgeW'(1);
         lane_phase_nx[i] = phase_ff[i];
         lane_skip_nx[i]  = skip_ff[i];
         lane_keep[i]     = 1'b0;
         lane_hit[i]      = 1'b0;
         if (valid_ff[i] && (lane_age_nx[i] < KillAge)) begin
            unique case (phase_ff[i])
               PH_SEARCH: begin
                  if (word.is_pkg) begin
                     lane_phase_nx[i] = PH_LEAD;
                     lane_keep[i]     = 1'b1;
                  end else if (lane_age_nx[i] < LastSearch) begin
                     lane_keep[i] = 1'b1;
                  end
               end
               PH_LEAD: begin
                  // skip the rest of the length field plus the count byte
                  lane_skip_nx[i]  = word.skip;
                  lane_phase_nx[i] = PH_SKIP;
                  lane_keep[i]     = 1'b1;
               end
               PH_SKIP: begin
                  lane_skip_nx[i] = skip_ff[i] - 3'd1;
                  if (skip_ff[i] == 3'd1)
                     lane_phase_nx[i] = PH_ELEM;
                  lane_keep[i] = 1'b1;
               end
               PH_ELEM: begin
                  if (word.is_prefix) begin
                     lane_phase_nx[i] = PH_VALUE;
                     lane_keep[i]     = 1'b1;
                  end else if (word.is_small) begin
                     lane_hit[i] = 1'b1;
                  end
               end
               PH_VALUE: begin
                  lane_hit[i] = 1'b1;
               end
               default: begin
                  lane_keep[i] = 1'b0;
               end
            endcase
         end
      end
   end

   // lowest free tracker after this word's drops
   always_comb begin
      ins_ok  = 1'b0;
      ins_idx = '0;
      for (int i = MAX_PENDING - 1; i >= 0; i--) begin
         if (!lane_keep[i]) begin
            ins_ok  = 1'b1;
            ins_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PENDING; i++) begin
         valid_in[i] = valid_ff[i];
         phase_in[i] = phase_ff[i];
         age_in[i]   = age_ff[i];
         skip_in[i]  = skip_ff[i];
         if (scan_live) begin
            valid_in[i] = lane_keep[i] && !success && !word.last;
            phase_in[i] = lane_phase_nx[i];
            age_in[i]   = lane_age_nx[i];
            skip_in[i]  = lane_skip_nx[i];
            if (word.name_hit && !success && ins_ok && (ins_idx == IdxW'(i))) begin
               valid_in[i] = 1'b1;
               phase_in[i] = PH_SEARCH;
               age_in[i]   = StartAge;
            end
         end
      end
   end

   always_comb begin
      answer_in = answer_ff;
      if (word_pop) begin
         if (answer_ff)
            answer_in = !word.last;
         else
            answer_in = success && !word.last;
      end
   end

   always_comb begin
      if (emit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         answer_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         answer_ff    <= answer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PENDING; i++) begin
         phase_ff[i] <= phase_in[i];
         age_ff[i]   <= age_in[i];
         skip_ff[i]  <= skip_in[i];
      end
      if (emit) begin
         rsp_found_ff <= success;
         rsp_bits_ff  <= success ?
                         16'({8'h00, word.data} << spbs_pkg::VALUE_SHIFT) : 16'h0000;
      end
   end

endmodule
`default_nettype wire

>>> design/sleep_package_byte_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleep_package_byte_scanner: top level
// Scans a table body for the sleep package name and recovers its sleep type
// as control bits, or reports not-found at the table's last byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/stall     data_byte, last_byte
//  rsp      out        rsp_valid/stall     found, sleep_control_bits
//
//  One byte per clock while rsp_stall is low; queue and result registered.
//  The match engine steps all open trackers together on each byte.
//  Synchronous reset empties the queue and the tracker list; no clearing pass.
//  A stalled result blocks the engine, and the four word queue then fills
//  before req_stall rises.
// ----------------------------------------------------------------------------
module sleep_package_byte_scanner #(
   parameter int MAX_PENDING = spbs_pkg::DEF_MAX_PENDING
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [15:0]      rsp_sleep_control_bits
);

   spbs_pkg::spbs_word_type push_word, pop_word;
   logic push_valid, queue_full, pop_valid, pop;

   spbs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_word     (push_word)
   );

   spbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop        (pop)
   );

   spbs_back #(
      .MAX_PENDING (MAX_PENDING)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .word_valid             (pop_valid),
      .word                   (pop_word),
      .word_pop               (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_found              (rsp_found),
      .rsp_sleep_control_bits (rsp_sleep_control_bits)
   );

endmodule
`default_nettype wire
